@@ sv/maf_pkg.sv @@
// ----------------------------------------------------------------------------
// maf_pkg
// Shared types, constants and helpers of the moving average filter.
// ----------------------------------------------------------------------------
package maf_pkg;

	localparam int WINDOW_MAX = 256;
	localparam int SLOT_W     = $clog2(WINDOW_MAX);
	localparam int TERM_W     = $clog2(WINDOW_MAX + 1);

	localparam int SAMPLE_W  = 32;
	localparam int SUM_W     = 40;
	localparam int NUM_W     = 56;
	localparam int CNT_W     = 32;
	localparam int DIVISOR_W = 64;
	localparam int QUOT_W    = NUM_W + 1;
	localparam int MUL_W     = 34;
	localparam int ACC_W     = 50;
	localparam int DIV_STEPS = NUM_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam logic [16:0] ALPHA_ONE = 17'h10000;

	localparam logic [1:0] MODE_SIMPLE   = 2'd0;
	localparam logic [1:0] MODE_WEIGHTED = 2'd1;
	localparam logic [1:0] MODE_EXP      = 2'd2;

	localparam logic [2:0] REG_MODE   = 3'd0;
	localparam logic [2:0] REG_WLEN   = 3'd1;
	localparam logic [2:0] REG_SKIP   = 3'd2;
	localparam logic [2:0] REG_STRICT = 3'd3;
	localparam logic [2:0] REG_ALPHA  = 3'd4;

	typedef struct packed {
		logic [1:0]  mode;
		logic [8:0]  wlen;
		logic [15:0] skip;
		logic        strict;
		logic [16:0] alpha;
	} cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       sample_empty;
		logic                       group_start;
		logic                       is_exp;
	} item_t;

	typedef struct packed {
		logic                        start;
		logic signed [NUM_W-1:0]     dividend;
		logic        [DIVISOR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                     busy;
		logic                     done;
		logic signed [QUOT_W-1:0] quotient;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_UPD,
		ST_WMUL,
		ST_WACC,
		ST_CHK,
		ST_DMUL,
		ST_DIVGO,
		ST_DIV,
		ST_EXPV,
		ST_EXPC,
		ST_EM1,
		ST_EM2,
		ST_EM3,
		ST_ESET,
		ST_RES
	} state_t;

	function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + CNT_W'(1);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end
		if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

endpackage

@@ sv/maf_ram.sv @@
// ----------------------------------------------------------------------------
// maf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module maf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ sv/maf_div.sv @@
// ----------------------------------------------------------------------------
// maf_div
// Radix-2 restoring divider, signed dividend by unsigned divisor, one
// quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module maf_div import maf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic                 neg_q;
	logic [STEP_W-1:0]    cnt_q;
	logic [NUM_W-1:0]     num_q;
	logic [DIVISOR_W-1:0] rem_q;
	logic [DIVISOR_W-1:0] div_q;

	logic [DIVISOR_W:0]   trial;
	logic                 ge;
	logic [NUM_W-1:0]     mag;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, div_q};
	assign mag   = req.dividend[NUM_W-1] ? NUM_W'(-req.dividend) : NUM_W'(req.dividend);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + STEP_W'(1);
				if (cnt_q == STEP_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.dividend[NUM_W-1];
			num_q <= mag;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? DIVISOR_W'(trial - {1'b0, div_q}) : trial[DIVISOR_W-1:0];
			num_q <= {num_q[NUM_W-2:0], ge};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});

endmodule

@@ sv/maf_front.sv @@
// ----------------------------------------------------------------------------
// maf_front
// Input side: takes stream transfers, tags each item with its mode class and
// holds up to two items for the back end.
// ----------------------------------------------------------------------------
module maf_front import maf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // sample
	input  logic [1:0]  s_axis_tuser,  // sample_empty, group_start
	output logic        q_valid,
	output item_t       q_item,
	input  logic        q_pop
);

	item_t      buf_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;
	item_t      in_item;

	assign s_axis_tready = cnt_q != 2'd2;
	assign push          = s_axis_tvalid && s_axis_tready;
	assign pop           = q_pop && q_valid;
	assign q_valid       = cnt_q != 2'd0;
	assign q_item        = buf_q[rd_q];

	always_comb begin
		in_item.sample       = s_axis_tdata;
		in_item.sample_empty = s_axis_tuser[0];
		in_item.group_start  = s_axis_tuser[1];
		in_item.is_exp       = cfg.mode == MODE_EXP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= in_item;
		end
	end

endmodule

@@ sv/maf_back.sv @@
// ----------------------------------------------------------------------------
// maf_back
// Execution side: window and smoothing state, shared multiplier, divider
// control and the output register.
// ----------------------------------------------------------------------------
module maf_back import maf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_valid,
	input  item_t       q_item,
	output logic        q_pop,
	output div_req_t    div_req,
	input  div_rsp_t    div_rsp,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // average
	output logic [0:0]  m_axis_tuser   // average_empty
);

	state_t state_q, state_d;

	logic signed [SAMPLE_W-1:0] x_q;
	logic                       emp_q;
	logic [SLOT_W-1:0]          ws_q;
	logic [WINDOW_MAX-1:0]      flags_q;
	logic signed [SUM_W-1:0]    rs_q;
	logic [NUM_W-1:0]           wn_q;
	logic [CNT_W-1:0]           vc_q;
	logic [CNT_W-1:0]           rc_q;
	logic signed [SAMPLE_W-1:0] sv_q;
	logic                       se_q;
	logic signed [2*MUL_W-1:0]  mul_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [SAMPLE_W-1:0] res_q;
	logic                       res_emp_q;
	logic                       ov_q;
	logic [SAMPLE_W-1:0]        od_q;
	logic                       oe_q;

	logic                       weighted;
	logic [TERM_W-1:0]          term;
	logic [SLOT_W-1:0]          slot;
	logic [SLOT_W:0]            slot_inc;
	logic signed [SAMPLE_W-1:0] v;
	logic signed [SAMPLE_W-1:0] old;
	logic [SAMPLE_W-1:0]        rdata;
	logic                       occ;
	logic signed [SUM_W-1:0]    rs_sub;
	logic [CNT_W-1:0]           vc_dec;
	logic                       ok;
	logic [16:0]                a17;
	logic signed [MUL_W-1:0]    mul_a;
	logic signed [MUL_W-1:0]    mul_b;
	logic signed [ACC_W-1:0]    exp_sum;
	logic signed [ACC_W-1:0]    exp_q;
	logic                       suppress;
	logic                       out_load;
	logic                       ram_we;

	assign weighted = cfg.mode == MODE_WEIGHTED;
	assign a17      = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
	assign v        = emp_q ? '0 : x_q;
	assign old      = rdata;
	assign slot     = (32'(ws_q) < 32'(WINDOW_MAX)) ? ws_q : '0;
	assign slot_inc = {1'b0, slot} + (SLOT_W+1)'(1);
	assign occ      = !flags_q[slot];
	assign rs_sub   = occ ? rs_q - SUM_W'(old) : rs_q;
	assign vc_dec   = (occ && vc_q != '0) ? vc_q - CNT_W'(1) : vc_q;
	assign ok       = cfg.strict ? (vc_q == CNT_W'(term)) : (vc_q != '0);
	assign suppress = rc_q <= CNT_W'(cfg.skip);
	assign exp_sum  = acc_q + mul_q[ACC_W-1:0];
	assign exp_q    = (exp_sum >>> 16) +
		$signed(ACC_W'(exp_sum[ACC_W-1] && exp_sum[15:0] != 16'd0));

	always_comb begin
		if (cfg.wlen == 9'd0) begin
			term = TERM_W'(1);
		end else if (32'(cfg.wlen) > 32'(WINDOW_MAX)) begin
			term = TERM_W'(WINDOW_MAX);
		end else begin
			term = TERM_W'(cfg.wlen);
		end
	end

	maf_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(WINDOW_MAX)
	) u_win (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot),
		.wdata (v),
		.raddr (slot),
		.rdata (rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					state_d = q_item.is_exp ? ST_EXPV : ST_READ;
				end
			end
			ST_READ:  state_d = ST_UPD;
			ST_UPD:   state_d = weighted ? ST_WMUL : ST_CHK;
			ST_WMUL:  state_d = ST_WACC;
			ST_WACC:  state_d = ST_CHK;
			ST_CHK: begin
				if (!ok) begin
					state_d = ST_RES;
				end else if (weighted) begin
					state_d = ST_DMUL;
				end else begin
					state_d = ST_DIVGO;
				end
			end
			ST_DMUL:  state_d = ST_DIVGO;
			ST_DIVGO: state_d = ST_DIV;
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_RES;
				end
			end
			ST_EXPV:  state_d = ST_EXPC;
			ST_EXPC: begin
				if (cfg.strict && vc_q != rc_q) begin
					state_d = ST_ESET;
				end else if (!emp_q && !se_q) begin
					state_d = ST_EM1;
				end else begin
					state_d = ST_ESET;
				end
			end
			ST_EM1:   state_d = ST_EM2;
			ST_EM2:   state_d = ST_EM3;
			ST_EM3:   state_d = ST_ESET;
			ST_ESET:  state_d = ST_RES;
			ST_RES: begin
				if (suppress || !ov_q || m_axis_tready) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_pop            = 1'b0;
		ram_we           = 1'b0;
		out_load         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = weighted ? $signed(wn_q) : NUM_W'(rs_q);
		div_req.divisor  = weighted ? mul_q[DIVISOR_W:1] : DIVISOR_W'(vc_q);
		mul_a            = '0;
		mul_b            = '0;
		case (state_q)
			ST_IDLE:  q_pop = q_valid;
			ST_UPD:   ram_we = 1'b1;
			ST_WMUL: begin
				mul_a = MUL_W'(v);
				mul_b = $signed({2'b00, vc_q});
			end
			ST_DMUL: begin
				mul_a = $signed({2'b00, vc_q});
				mul_b = $signed({1'b0, {1'b0, vc_q} + 33'd1});
			end
			ST_DIVGO: div_req.start = 1'b1;
			ST_EM1: begin
				mul_a = $signed({17'd0, a17});
				mul_b = MUL_W'(x_q);
			end
			ST_EM2: begin
				mul_a = $signed({17'd0, ALPHA_ONE - a17});
				mul_b = MUL_W'(sv_q);
			end
			ST_RES:   out_load = !suppress && (!ov_q || m_axis_tready);
			default:  q_pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ws_q    <= '0;
			flags_q <= '1;
			rs_q    <= '0;
			wn_q    <= '0;
			vc_q    <= '0;
			rc_q    <= '0;
			sv_q    <= '0;
			se_q    <= 1'b1;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (m_axis_tready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						if (q_item.group_start) begin
							ws_q    <= '0;
							flags_q <= '1;
							rs_q    <= '0;
							wn_q    <= '0;
							vc_q    <= '0;
							sv_q    <= '0;
							se_q    <= 1'b1;
							rc_q    <= CNT_W'(1);
						end else begin
							rc_q <= inc_sat(rc_q);
						end
					end
				end
				ST_UPD: begin
					if (occ && weighted) begin
						wn_q <= wn_q - NUM_W'(rs_q);
					end
					rs_q          <= rs_sub + SUM_W'(v);
					vc_q          <= emp_q ? vc_dec : inc_sat(vc_dec);
					flags_q[slot] <= emp_q;
					ws_q          <= (32'(slot_inc) >= 32'(term)) ? '0 : slot_inc[SLOT_W-1:0];
				end
				ST_WACC: wn_q <= wn_q + mul_q[NUM_W-1:0];
				ST_EXPV: begin
					if (!emp_q) begin
						vc_q <= inc_sat(vc_q);
					end
				end
				ST_EXPC: begin
					if (cfg.strict && vc_q != rc_q) begin
						se_q <= 1'b1;
					end else if (!emp_q && se_q) begin
						sv_q <= x_q;
						se_q <= 1'b0;
					end
				end
				ST_EM3: sv_q <= sat32(64'(exp_q));
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
		if (state_q == ST_IDLE && q_valid) begin
			x_q   <= q_item.sample;
			emp_q <= q_item.sample_empty;
		end
		if (state_q == ST_EM2) begin
			acc_q <= mul_q[ACC_W-1:0];
		end
		if (state_q == ST_CHK && !ok) begin
			res_q     <= '0;
			res_emp_q <= 1'b1;
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			res_q     <= sat32(64'(div_rsp.quotient));
			res_emp_q <= 1'b0;
		end
		if (state_q == ST_ESET) begin
			res_q     <= se_q ? '0 : sv_q;
			res_emp_q <= se_q;
		end
		if (out_load) begin
			od_q <= res_emp_q ? '0 : res_q;
			oe_q <= res_emp_q;
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = od_q;
	assign m_axis_tuser  = oe_q;

endmodule

@@ sv/moving_average_filter_core.sv @@
// ----------------------------------------------------------------------------
// moving_average_filter_core
// Simple, linear weighted and exponential moving average of Q16.16 samples.
// Window modes divide with the 56-step radix-2 divider. Items are handled one
// at a time; a 2-entry queue and the output register let input and output
// stall independently.
// Reset: arst_n clears control, window and smoothing state, window flags read empty, registers default.
// ----------------------------------------------------------------------------
module moving_average_filter_core import maf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // sample
	input  logic [1:0]  s_axis_tuser,  // sample_empty, group_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // average
	output logic [0:0]  m_axis_tuser   // average_empty
);

	cfg_t     cfg_q;
	logic     wr;
	logic     q_valid;
	item_t    q_item;
	logic     q_pop;
	div_req_t div_req;
	div_rsp_t div_rsp;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode   <= MODE_SIMPLE;
			cfg_q.wlen   <= 9'd1;
			cfg_q.skip   <= 16'd0;
			cfg_q.strict <= 1'b0;
			cfg_q.alpha  <= 17'd32768;
		end else if (wr) begin
			case (paddr[4:2])
				REG_MODE:   cfg_q.mode   <= pwdata[1:0];
				REG_WLEN:   cfg_q.wlen   <= pwdata[8:0];
				REG_SKIP:   cfg_q.skip   <= pwdata[15:0];
				REG_STRICT: cfg_q.strict <= pwdata[0];
				REG_ALPHA:  cfg_q.alpha  <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_MODE:   prdata = 32'(cfg_q.mode);
			REG_WLEN:   prdata = 32'(cfg_q.wlen);
			REG_SKIP:   prdata = 32'(cfg_q.skip);
			REG_STRICT: prdata = 32'(cfg_q.strict);
			REG_ALPHA:  prdata = 32'(cfg_q.alpha);
			default:    prdata = 32'd0;
		endcase
	end

	maf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop)
	);

	maf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	maf_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.div_req       (div_req),
		.div_rsp       (div_rsp),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 32'd0)
		else $error("empty result with nonzero data");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider started while busy");

	a_div_runs: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |=> div_rsp.busy)
		else $error("divider did not start");

	a_queue_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> q_valid)
		else $error("accepted transfer not queued");

endmodule
